// ----- rtl/sha512_pkg.sv -----
// shared types, constants and the rotate function for the sha-512 hasher
package sha512_pkg;

	localparam int unsigned Rounds = 80;
	localparam int unsigned BlockBytes = 128;
	localparam int unsigned BlockWords = BlockBytes / 8;
	localparam int unsigned RoundW = $clog2(Rounds);
	localparam int unsigned SlotW = $clog2(BlockWords);
	localparam int unsigned LenSlot = BlockWords - 2;

	localparam logic [63:0] IvReset [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] RoundConsts [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	// word source for a block push
	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} push_src_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic      msg_start;
		logic      push;
		push_src_t src;
		logic      add_len;
		logic      round_init;
		logic      round_step;
		logic      fold;
		logic      emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic block_full;
		logic rounds_done;
		logic past_len_slot;
		logic at_len_slot;
		logic emit_done;
	} dp_status_t;

	function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned r);
		ror64 = (x >> r) | (x << (64 - r));
	endfunction

endpackage

// ----- rtl/sha512_ctrl.sv -----
// controller state machine for the sha-512 hasher
module sha512_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   final_word,
	input  logic [3:0]             valid_bytes,
	input  sha512_pkg::dp_status_t status,
	output sha512_pkg::dp_cmd_t    cmd,
	output logic                   busy
);

	sha512_pkg::state_t state_q, state_d;
	logic               in_msg_q;
	// pad plan for the tail: data word, pad word, fill zeros, length
	logic               need_data_q, need_pad_q, tail_q, closing_q;
	logic               need_data_d, need_pad_d, tail_d, closing_d;
	sha512_pkg::push_src_t src;
	logic               vb_full, vb_zero;
	// remember whether the block just compressed held the length
	logic               src_was_len_q;

	assign vb_full = (valid_bytes >= 4'd8);
	assign vb_zero = (valid_bytes == 4'd0);

	// select push word for the current step
	always_comb begin
		if (need_data_q)
			src = sha512_pkg::SRC_DATA;
		else if (need_pad_q)
			src = sha512_pkg::SRC_PAD;
		else if (!tail_q && status.at_len_slot)
			src = sha512_pkg::SRC_LEN;
		else
			src = sha512_pkg::SRC_ZERO;
	end

	// next state
	always_comb begin
		state_d     = state_q;
		need_data_d = need_data_q;
		need_pad_d  = need_pad_q;
		tail_d      = tail_q;
		closing_d   = closing_q;
		case (state_q)
			sha512_pkg::ST_IDLE: begin
				if (start) begin
					state_d     = sha512_pkg::ST_PUSH;
					closing_d   = final_word;
					need_data_d = !final_word || !vb_zero;
					need_pad_d  = final_word && (vb_zero || vb_full);
					tail_d      = 1'b0;
				end
			end
			sha512_pkg::ST_PUSH: begin
				// track pad plan; tail set when pad lands in or beyond the length slot
				if (need_data_q)
					need_data_d = 1'b0;
				else if (need_pad_q)
					need_pad_d = 1'b0;
				if (closing_q && ((need_data_q && !need_pad_q) || (!need_data_q && need_pad_q))
						&& status.past_len_slot)
					tail_d = 1'b1;
				if (status.block_full)
					state_d = sha512_pkg::ST_ROUND;
				else if (!closing_q || (src == sha512_pkg::SRC_DATA && !need_pad_q
						&& !closing_q))
					state_d = sha512_pkg::ST_IDLE;
				else if (src == sha512_pkg::SRC_LEN)
					state_d = sha512_pkg::ST_PUSH;
				if (!closing_q && !status.block_full)
					state_d = sha512_pkg::ST_IDLE;
			end
			sha512_pkg::ST_ROUND: begin
				if (status.rounds_done)
					state_d = sha512_pkg::ST_FOLD;
			end
			sha512_pkg::ST_FOLD: begin
				if (!closing_q)
					state_d = sha512_pkg::ST_IDLE;
				else if (!need_data_q && !need_pad_q && !tail_q && src_was_len_q)
					state_d = sha512_pkg::ST_EMIT;
				else begin
					state_d = sha512_pkg::ST_PUSH;
					tail_d  = 1'b0;
				end
			end
			sha512_pkg::ST_EMIT: begin
				if (status.emit_done)
					state_d = sha512_pkg::ST_IDLE;
			end
			default: state_d = sha512_pkg::ST_IDLE;
		endcase
	end

	// length marker for the block being filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			src_was_len_q <= 1'b0;
		else if (state_q == sha512_pkg::ST_PUSH)
			src_was_len_q <= (src == sha512_pkg::SRC_LEN);
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.src    = src;
		busy       = (state_q != sha512_pkg::ST_IDLE);
		case (state_q)
			sha512_pkg::ST_IDLE: begin
				cmd.msg_start = start && !in_msg_q;
				cmd.add_len   = start;
			end
			sha512_pkg::ST_PUSH: begin
				cmd.push       = 1'b1;
				cmd.round_init = status.block_full;
			end
			sha512_pkg::ST_ROUND: cmd.round_step = 1'b1;
			sha512_pkg::ST_FOLD:  cmd.fold = 1'b1;
			sha512_pkg::ST_EMIT:  cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha512_pkg::ST_IDLE;
			in_msg_q    <= 1'b0;
			need_data_q <= 1'b0;
			need_pad_q  <= 1'b0;
			tail_q      <= 1'b0;
			closing_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			need_data_q <= need_data_d;
			need_pad_q  <= need_pad_d;
			tail_q      <= tail_d;
			closing_q   <= closing_d;
			if (state_q == sha512_pkg::ST_IDLE && start)
				in_msg_q <= !final_word;
		end
	end

endmodule

// ----- rtl/sha512_datapath.sv -----
// datapath: block buffer, schedule ring, round unit, chaining words
module sha512_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [63:0]            iv_q [8],
	input  logic [63:0]            data_word,
	input  logic [3:0]             valid_bytes,
	input  logic                   final_word,
	input  sha512_pkg::dp_cmd_t    cmd,
	output sha512_pkg::dp_status_t status,
	output logic                   digest_valid,
	output logic [63:0]            digest_word,
	output logic [2:0]             digest_index,
	output logic                   digest_last
);

	logic [63:0] chain_q [8];
	logic [63:0] var_q [8];
	logic [63:0] ring_q [16];
	logic [63:0] bits_q;
	logic [63:0] data_q;
	logic [3:0]  nb_q;
	logic [3:0]  wcnt_q;
	logic [sha512_pkg::RoundW-1:0] rnd_q;
	logic [2:0]  eidx_q;
	logic        dvalid_q;
	logic [63:0] dword_q;
	logic [2:0]  didx_q;

	logic [63:0] push_word, keep, padbit, w, w15, w2, w7, w16, g0, g1, wnew;
	logic [63:0] s0, s1, maj, ch, t1, t2;
	logic [5:0]  sh;
	logic [3:0]  nb_c;
	logic [3:0]  slot;

	assign nb_c = (nb_q > 4'd8) ? 4'd8 : nb_q;
	assign sh   = 6'(8 * (8 - nb_c));

	// partial word with pad bit after the last valid byte
	always_comb begin
		keep   = (nb_c == 4'd0) ? 64'd0 : (~64'd0 << sh);
		padbit = 64'h80 << sh;
		padbit = (nb_c == 4'd8) ? 64'd0 : (padbit >> 8);
		case (cmd.src)
			sha512_pkg::SRC_DATA: push_word = (nb_c == 4'd8) ? data_q : ((data_q & keep) | padbit);
			sha512_pkg::SRC_PAD:  push_word = 64'h8000000000000000;
			sha512_pkg::SRC_LEN:  push_word = bits_q;
			default:              push_word = 64'd0;
		endcase
	end

	// message schedule for the current round
	always_comb begin
		slot = rnd_q[3:0];
		w16  = ring_q[slot];
		w15  = ring_q[4'(slot + 4'd1)];
		w2   = ring_q[4'(slot + 4'd14)];
		w7   = ring_q[4'(slot + 4'd9)];
		g0   = sha512_pkg::ror64(w15, 1) ^ sha512_pkg::ror64(w15, 8) ^ (w15 >> 7);
		g1   = sha512_pkg::ror64(w2, 19) ^ sha512_pkg::ror64(w2, 61) ^ (w2 >> 6);
		wnew = w16 + g0 + w7 + g1;
		w    = (rnd_q < 7'(sha512_pkg::BlockWords)) ? w16 : wnew;
	end

	// one compression round
	always_comb begin
		s0  = sha512_pkg::ror64(var_q[0], 28) ^ sha512_pkg::ror64(var_q[0], 34)
			^ sha512_pkg::ror64(var_q[0], 39);
		s1  = sha512_pkg::ror64(var_q[4], 14) ^ sha512_pkg::ror64(var_q[4], 18)
			^ sha512_pkg::ror64(var_q[4], 41);
		maj = (var_q[1] & var_q[2]) | (var_q[0] & (var_q[1] ^ var_q[2]));
		ch  = var_q[6] ^ (var_q[4] & (var_q[5] ^ var_q[6]));
		t2  = s0 + maj;
		t1  = var_q[7] + s1 + ch + sha512_pkg::RoundConsts[rnd_q] + w;
	end

	assign status.block_full    = (wcnt_q == 4'd15);
	assign status.rounds_done   = (rnd_q == 7'(sha512_pkg::Rounds - 1));
	assign status.past_len_slot = (wcnt_q > 4'(sha512_pkg::LenSlot - 1));
	assign status.at_len_slot   = (wcnt_q == 4'(sha512_pkg::LenSlot + 1));
	assign status.emit_done     = (eidx_q == 3'd7);

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q   <= '0;
			rnd_q    <= '0;
			eidx_q   <= '0;
			bits_q   <= '0;
			dvalid_q <= 1'b0;
		end else begin
			dvalid_q <= cmd.emit;
			if (cmd.msg_start)
				wcnt_q <= '0;
			// a message start always comes with a length update
			if (cmd.add_len)
				bits_q <= (cmd.msg_start ? 64'd0 : bits_q)
					+ (final_word ? 64'(((valid_bytes > 4'd8) ? 4'd8 : valid_bytes)) << 3 : 64'd64);
			if (cmd.push)
				wcnt_q <= wcnt_q + 4'd1;
			if (cmd.round_step)
				rnd_q <= status.rounds_done ? '0 : rnd_q + 7'd1;
			if (cmd.emit)
				eidx_q <= eidx_q + 3'd1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.add_len) begin
			data_q <= data_word;
			nb_q   <= final_word ? valid_bytes : 4'd8;
		end
		if (cmd.msg_start)
			for (int i = 0; i < 8; i++) chain_q[i] <= iv_q[i];
		if (cmd.push)
			ring_q[wcnt_q] <= push_word;
		if (cmd.round_init)
			for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
		if (cmd.round_step) begin
			if (rnd_q >= 7'(sha512_pkg::BlockWords))
				ring_q[slot] <= wnew;
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
		if (cmd.fold)
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
		if (cmd.emit) begin
			dword_q <= chain_q[eidx_q];
			didx_q  <= eidx_q;
		end
	end

	assign digest_valid = dvalid_q;
	assign digest_word  = dword_q;
	assign digest_index = didx_q;
	assign digest_last  = (didx_q == 3'd7);

endmodule

// ----- rtl/sha512_message_hasher.sv -----
// sha-512 message hasher top level
// a word that does not fill a block is accepted and pushed, then the block is idle again; the word
// that fills a block is accepted, pushed, then runs the sha-512 rounds and the fold before idle.
// a final word pushes pad, zeros and length one word per cycle, with rounds and fold per block,
// then emits eight digest words on consecutive cycles with digest_valid; no receiver stall.
// reset restores the sha-512 initial value and clears all control state.
module sha512_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        final_word,
	output logic        digest_valid,
	output logic [63:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_last
);

	logic [63:0]            iv_q [8];
	sha512_pkg::dp_cmd_t    cmd;
	sha512_pkg::dp_status_t status;

	// initial value registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) iv_q[i] <= sha512_pkg::IvReset[i];
		end else if (cfg_we) begin
			iv_q[cfg_index] <= cfg_data;
		end
	end

	sha512_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_word (final_word),
		.valid_bytes(valid_bytes),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy)
	);

	sha512_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.iv_q        (iv_q),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.final_word  (final_word),
		.cmd         (cmd),
		.status      (status),
		.digest_valid(digest_valid),
		.digest_word (digest_word),
		.digest_index(digest_index),
		.digest_last (digest_last)
	);

endmodule

// ----- tb/tb_sha512_message_hasher.sv -----
// testbench for the sha-512 message hasher: directed and random messages against a predictor
module tb_sha512_message_hasher;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] data_word = '0;
	logic [3:0]  valid_bytes = '0;
	logic        final_word = 1'b0;
	logic        digest_valid;
	logic [63:0] digest_word;
	logic [2:0]  digest_index;
	logic        digest_last;

	sha512_message_hasher dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [63:0] iv_regs [8];
	logic [63:0] hash_state [8];
	logic [63:0] block_buf [16];
	logic [63:0] bit_len;
	int          words_held;
	bit          msg_open;
	digest_t     pending_digests [$];
	bit          failed;
	int          send_gap_pct;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int r);
		return (x >> r) | (x << (64 - r));
	endfunction

	// one full sha-512 compression of block_buf into hash_state
	function automatic void compress();
		logic [63:0] w [80];
		logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 80; i++) begin
			if (i < 16) w[i] = block_buf[i];
			else w[i] = w[i-16] + (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7))
				+ w[i-7] + (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6));
		end
		{a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
			hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
		for (int i = 0; i < 80; i++) begin
			t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
				+ sha512_pkg::RoundConsts[i] + w[i];
			t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endfunction

	function automatic void add_word(input logic [63:0] w);
		block_buf[words_held] = w;
		words_held++;
		if (words_held == 16) begin
			compress();
			words_held = 0;
		end
	endfunction

	// expected digests for one accepted request
	function automatic void predict_digest(input logic [63:0] d, input logic [3:0] nb,
			input logic fin);
		int n;
		digest_t r;
		if (!msg_open) begin
			hash_state = iv_regs;
			bit_len = '0;
			words_held = 0;
			msg_open = 1'b1;
		end
		if (!fin) begin
			bit_len += 64;
			add_word(d);
			return;
		end
		n = (nb > 8) ? 8 : nb;
		bit_len += 64'(8 * n);
		if (n == 8) begin
			add_word(d);
			add_word(64'h80 << 56);
		end else if (n == 0) begin
			add_word(64'h80 << 56);
		end else begin
			add_word((d & (~64'd0 << (64 - 8 * n))) | (64'h80 << (56 - 8 * n)));
		end
		if (words_held > 14)
			while (words_held != 0) add_word('0);
		while (words_held < 14) add_word('0);
		add_word('0);
		add_word(bit_len);
		for (int j = 0; j < 8; j++) begin
			r.word = hash_state[j];
			r.index = 3'(j);
			r.last = (j == 7);
			pending_digests.push_back(r);
		end
		msg_open = 1'b0;
	endfunction

	// digest checker
	always @(posedge clk) begin
		digest_t exp_d;
		if (arst_n && digest_valid) begin
			if (pending_digests.size() == 0) begin
				$error("unexpected digest word %h", digest_word);
				failed = 1'b1;
			end else begin
				exp_d = pending_digests.pop_front();
				if (digest_word !== exp_d.word) begin
					$error("digest_word expected %h actual %h", exp_d.word, digest_word);
					failed = 1'b1;
				end
				if (digest_index !== exp_d.index) begin
					$error("digest_index expected %0d actual %0d", exp_d.index, digest_index);
					failed = 1'b1;
				end
				if (digest_last !== exp_d.last) begin
					$error("digest_last expected %0d actual %0d", exp_d.last, digest_last);
					failed = 1'b1;
				end
			end
		end
	end

	// send one request and wait for its acceptance; the block is busy in the cycle after
	task automatic send_word(input logic [63:0] d, input logic [3:0] nb, input logic fin);
		while ($urandom_range(99) < send_gap_pct) @(posedge clk);
		start <= 1'b1;
		data_word <= d;
		valid_bytes <= nb;
		final_word <= fin;
		do @(posedge clk); while (busy);
		predict_digest(d, nb, fin);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_message(input int nwords, input logic [3:0] nb);
		for (int i = 0; i < nwords; i++)
			send_word({$urandom, $urandom}, 4'($urandom), 1'b0);
		send_word({$urandom, $urandom}, nb, 1'b1);
	endtask

	task automatic wait_drained();
		while (pending_digests.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_iv(input int idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= 3'(idx);
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		iv_regs[idx] = v;
		@(posedge clk);
	endtask

	// every byte count, empty message, block boundaries and second pad block
	task automatic test_directed();
		send_word('1, 4'd0, 1'b1);
		for (int nb = 0; nb <= 15; nb++) send_message(0, 4'(nb));
		send_message(13, 4'd8);
		send_message(14, 4'd0);
		send_message(15, 4'd8);
		send_message(16, 4'd0);
		send_message(0, 4'd8);
		send_word('0, 4'd8, 1'b1);
		wait_drained();
	endtask

	task automatic test_iv_settings();
		for (int i = 0; i < 8; i++) write_iv(i, '0);
		send_message(2, 4'd5);
		wait_drained();
		for (int i = 0; i < 8; i++) write_iv(i, '1);
		send_message(17, 4'd3);
		wait_drained();
		for (int i = 0; i < 8; i++) write_iv(i, {$urandom, $urandom});
		send_message(5, 4'd8);
		wait_drained();
		// back to the sha-512 initial value
		for (int i = 0; i < 8; i++) write_iv(i, sha512_pkg::IvReset[i]);
	endtask

	task automatic test_random(input int gap_pct, input int nwords);
		int sent;
		int len;
		send_gap_pct = gap_pct;
		sent = 0;
		while (sent < nwords) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(18);
			send_message(len, 4'($urandom_range(15)));
			sent += len + 1;
		end
		wait_drained();
	endtask

	initial begin
		iv_regs = sha512_pkg::IvReset;
		msg_open = 1'b0;
		words_held = 0;
		bit_len = '0;
		failed = 1'b0;
		send_gap_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_iv_settings();
		test_random(25, 120);
		test_random(64, 120);
		test_random(0, 120);
		if (failed)
			$display("tb_sha512_message_hasher failed");
		else
			$display("tb_sha512_message_hasher passed");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_sha512_message_hasher failed");
		$finish;
	end
endmodule

// ----- sha512_message_hasher.f -----
rtl/sha512_pkg.sv
rtl/sha512_ctrl.sv
rtl/sha512_datapath.sv
rtl/sha512_message_hasher.sv
tb/tb_sha512_message_hasher.sv
